// ----- design/trial_division_divisor_scan_top_defines.svh -----
// Assertion helpers shared by the design files.
`ifndef TRIAL_DIVISION_DIVISOR_SCAN_TOP_DEFINES_SVH
`define TRIAL_DIVISION_DIVISOR_SCAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TDS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tds assertion failed");
// Antecedent in this cycle implies consequent in this cycle.
`define TDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tds assertion failed");
// Antecedent in this cycle implies consequent in the next cycle.
`define TDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tds assertion failed");
`else
`define TDS_ASSERT(lbl, clk, rst, prop)
`define TDS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- design/tds_pkg.sv -----
package tds_pkg;

   localparam int unsigned DATA_W       = 64;
   localparam int unsigned DIV_CNT_W    = $clog2(DATA_W);
   localparam int unsigned MAX_SPAN_DEF = 64;

   typedef struct packed {
      logic [DATA_W-1:0] range_first;
      logic [DATA_W-1:0] range_last;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] divisor;
      logic [DATA_W-1:0] cofactor;
      logic              pair_valid;
      logic              span_error;
      logic              last_of_run;
   } rsp_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic              busy;
      logic              done;
      logic              exact;
      logic [DATA_W-1:0] quotient;
   } div_res_type;

endpackage

// ----- design/tds_divider.sv -----
`include "trial_division_divisor_scan_top_defines.svh"

module tds_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tds_pkg::DATA_W-1:0]   dividend,
   input  logic [tds_pkg::DATA_W-1:0]   divisor,
   output tds_pkg::div_res_type         res
);
   import tds_pkg::*;

   // restoring divider, one quotient bit per cycle
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [DATA_W:0]      shifted;
   logic [DATA_W+1:0]    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_W+1]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   always_comb begin
      res.busy     = busy_ff;
      res.done     = done_ff;
      res.exact    = (rem_ff == '0);
      res.quotient = quo_ff;
   end

   `TDS_ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff)
   `TDS_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)
   `TDS_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

// ----- design/trial_division_divisor_scan_top.sv -----
// Trial-division divisor scan.
// Target number is loaded through csr_we / csr_wdata and applies to every
// range until rewritten; write it only while busy is low.
// A request (range_first .. range_last, inclusive) is taken on a clock edge
// with start high and busy low. busy stays high until the last response has
// been issued.
// Responses appear on rsp_data for one cycle each with rsp_valid high, in
// rising divisor order; the final one carries last_of_run. A range with no
// divisor gives one response with pair_valid low; a reversed range or one
// wider than MaxSpan gives one response with span_error set.
// Sequence: a range check, then per nonzero candidate a launch, a wait on
// the 64-step bit-serial divider and a collect; candidate zero is skipped
// without a division. Each response is registered. A rejected range is
// answered from the range check.
// A found pair is held back one step so the last one can be marked.
// The receiver cannot stall; each response is valid for exactly one cycle.
// Reset (synchronous) clears the target to zero and aborts any scan in
// flight without a response.
`include "trial_division_divisor_scan_top_defines.svh"

module trial_division_divisor_scan_top #(
   parameter int unsigned MaxSpan = tds_pkg::MAX_SPAN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tds_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output tds_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [tds_pkg::DATA_W-1:0]  csr_wdata
);
   import tds_pkg::*;

   localparam int unsigned SpanW = $clog2(MaxSpan + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_LAUNCH = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_NEXT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [DATA_W-1:0] target_ff, target_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic [DATA_W-1:0] last_ff, last_in;
   logic [DATA_W-1:0] cand_ff, cand_in;
   logic [SpanW-1:0]  left_ff, left_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [DATA_W-1:0] pend_div_ff, pend_div_in;
   logic [DATA_W-1:0] pend_cof_ff, pend_cof_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [DATA_W:0]   extent;
   logic              span_bad;
   logic              div_start;
   div_res_type       div_res;

   // range check: borrow flags a reversed range, extent = candidates - 1
   always_comb begin
      extent   = {1'b0, last_ff} - {1'b0, first_ff};
      span_bad = extent[DATA_W]
              || (extent[DATA_W-1:SpanW] != '0)
              || (extent[SpanW-1:0] >= SpanW'(MaxSpan));
   end

   assign div_start = (state_ff == S_LAUNCH) && (cand_ff != '0);

   tds_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (target_ff),
      .divisor  (cand_ff),
      .res      (div_res)
   );

   always_comb begin
      state_in      = state_ff;
      target_in     = csr_we ? csr_wdata : target_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      cand_in       = cand_ff;
      left_in       = left_ff;
      pend_valid_in = pend_valid_ff;
      pend_div_in   = pend_div_ff;
      pend_cof_in   = pend_cof_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               first_in = req_data.range_first;
               last_in  = req_data.range_last;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            pend_valid_in = 1'b0;
            cand_in       = first_ff;
            left_in       = extent[SpanW-1:0];
            if (span_bad) begin
               rsp_valid_in       = 1'b1;
               rsp_in.divisor     = '0;
               rsp_in.cofactor    = '0;
               rsp_in.pair_valid  = 1'b0;
               rsp_in.span_error  = 1'b1;
               rsp_in.last_of_run = 1'b1;
               state_in           = S_IDLE;
            end else begin
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            // candidate zero is skipped
            state_in = (cand_ff == '0) ? S_NEXT : S_WAIT;
         end
         S_WAIT: begin
            if (div_res.done) begin
               if (div_res.exact) begin
                  // release the previous pair, keep this one back
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.divisor     = pend_div_ff;
                     rsp_in.cofactor    = pend_cof_ff;
                     rsp_in.pair_valid  = 1'b1;
                     rsp_in.span_error  = 1'b0;
                     rsp_in.last_of_run = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_div_in   = cand_ff;
                  pend_cof_in   = div_res.quotient;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (left_ff == '0) begin
               rsp_valid_in       = 1'b1;
               rsp_in.divisor     = pend_valid_ff ? pend_div_ff : '0;
               rsp_in.cofactor    = pend_valid_ff ? pend_cof_ff : '0;
               rsp_in.pair_valid  = pend_valid_ff;
               rsp_in.span_error  = 1'b0;
               rsp_in.last_of_run = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = S_IDLE;
            end else begin
               cand_in  = cand_ff + 1'b1;
               left_in  = left_ff - 1'b1;
               state_in = S_LAUNCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         target_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         target_ff     <= target_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      last_ff     <= last_in;
      cand_ff     <= cand_in;
      left_ff     <= left_in;
      pend_div_ff <= pend_div_in;
      pend_cof_ff <= pend_cof_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // rejected range: single closing response, never a pair
   `TDS_ASSERT_IMP(a_err_closes, clock, reset, rsp_valid_ff && rsp_ff.span_error, !rsp_ff.pair_valid && rsp_ff.last_of_run)
   // a response without a pair always ends the run
   `TDS_ASSERT_IMP(a_nopair_last, clock, reset, rsp_valid_ff && !rsp_ff.pair_valid, rsp_ff.last_of_run)
   // divisor zero is never reported
   `TDS_ASSERT_IMP(a_pair_nonzero, clock, reset, rsp_valid_ff && rsp_ff.pair_valid, rsp_ff.divisor != '0)
   // a division is only launched on an idle divider
   `TDS_ASSERT_IMP(a_launch_idle, clock, reset, div_start, !div_res.busy)

endmodule

// ----- test/trial_division_divisor_scan_top_tb.sv -----
`timescale 1ns / 1ps

module trial_division_divisor_scan_top_tb;

   localparam logic [63:0] TOP_VALUE = {64{1'b1}};
   localparam int unsigned SPAN_LIMIT = tds_pkg::MAX_SPAN_DEF;
   localparam int unsigned IDLE_LIMIT = 25000;
   localparam int unsigned SETTLE_CYCLES = 150;
   localparam int unsigned RANDOM_PHASES = 7;
   localparam int unsigned PHASE_RANGES = 17;

   // kinds of work the driver takes from its queue
   typedef enum logic {
      ENTRY_RANGE,
      ENTRY_TARGET
   } entry_kind_type;

   typedef struct {
      entry_kind_type   kind;
      tds_pkg::req_type req;
      logic [63:0]      value;
      int unsigned      gap;
   } work_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tds_pkg::req_type req_data = '0;
   logic rsp_valid;
   tds_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [tds_pkg::DATA_W-1:0] csr_wdata = '0;

   work_item_type work_q[$];
   tds_pkg::rsp_type divisor_results_q[$];

   // driver's copy of the target register
   logic [63:0] target_shadow = '0;
   // target the stimulus is being built against
   logic [63:0] plan_target = '0;
   bit burst_mode = 1'b0;

   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_cnt = 0;
   int unsigned req_gap = 0;
   logic start_nxt;
   logic we_nxt;

   trial_division_divisor_scan_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: walk the candidates of the range in rising order, one
   // result per exact divisor. Candidate zero is skipped. A pair is held
   // back one step so the final one can carry last_of_run.
   // ---------------------------------------------------------------------
   function automatic void scan_divisors(input tds_pkg::req_type rq);
      logic [63:0] extent;
      logic [63:0] cand;
      int unsigned k;
      bit have_held;
      tds_pkg::rsp_type held;
      tds_pkg::rsp_type r;
      have_held = 1'b0;
      held = '0;
      r = '0;
      r.last_of_run = 1'b1;
      extent = rq.range_last - rq.range_first;
      // reversed range, or wider than the span limit: lone error result
      if (rq.range_last < rq.range_first || extent >= 64'(SPAN_LIMIT)) begin
         r.span_error = 1'b1;
         divisor_results_q.push_back(r);
         return;
      end
      for (k = 0; k <= extent; k++) begin
         cand = rq.range_first + 64'(k);
         if (cand != '0 && target_shadow % cand == '0) begin
            if (have_held)
               divisor_results_q.push_back(held);
            held = '0;
            held.divisor = cand;
            held.cofactor = target_shadow / cand;
            held.pair_valid = 1'b1;
            have_held = 1'b1;
         end
      end
      if (have_held) begin
         held.last_of_run = 1'b1;
         divisor_results_q.push_back(held);
      end else begin
         // nothing divides: lone empty result
         divisor_results_q.push_back(r);
      end
   endfunction

   function automatic int unsigned draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic void add_range(input logic [63:0] first, input logic [63:0] last);
      work_item_type w;
      w.kind = ENTRY_RANGE;
      w.req.range_first = first;
      w.req.range_last = last;
      w.value = '0;
      w.gap = draw_gap();
      work_q.push_back(w);
   endfunction

   // target writes wait for the block to drain, so each one is also a
   // point where the sender stops until every result is in
   function automatic void add_target(input logic [63:0] value);
      work_item_type w;
      w.kind = ENTRY_TARGET;
      w.req = '0;
      w.value = value;
      w.gap = 0;
      work_q.push_back(w);
      plan_target = value;
   endfunction

   // product of small factors: plenty of divisors at both ends
   function automatic logic [63:0] smooth_number();
      logic [63:0] v;
      logic [63:0] m;
      int unsigned n;
      v = 64'd1;
      for (n = 0; n < 40; n++) begin
         m = 64'($urandom_range(2, 40));
         if (v > TOP_VALUE / m)
            break;
         v = v * m;
      end
      return v;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // One random range. Mostly well formed and placed near likely divisors
   // (small ones, target / small, the top of the value space); the rest
   // is reversed or too wide.
   function automatic void add_random_range();
      logic [63:0] anchor;
      logic [63:0] ext;
      logic [63:0] sub;
      logic [63:0] first;
      logic [63:0] last;
      logic [63:0] a;
      logic [63:0] b;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         case ($urandom_range(0, 5))
            0, 1: anchor = 64'($urandom_range(0, 300));
            2, 3: anchor = plan_target / 64'($urandom_range(1, 64));
            4: anchor = TOP_VALUE - 64'($urandom_range(0, 80));
            default: anchor = rand64();
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 75)
            ext = 64'($urandom_range(0, 7));
         else if (pick < 92)
            ext = 64'($urandom_range(8, SPAN_LIMIT - 1));
         else
            ext = 64'(SPAN_LIMIT - 1);
         sub = 64'($urandom_range(0, 32'(ext)));
         first = (anchor < sub) ? '0 : anchor - sub;
         last = first + ext;
         if (last < first)
            last = TOP_VALUE;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               // reversed
               a = rand64();
               b = rand64();
               if (a == b)
                  b = a ^ 64'd1;
               first = (a > b) ? a : b;
               last = (a > b) ? b : a;
            end
            1: begin
               // one past the span limit
               first = 64'($urandom_range(0, 1000));
               last = first + 64'(SPAN_LIMIT);
            end
            2: begin
               first = rand64();
               last = first + 64'($urandom_range(SPAN_LIMIT, 5000));
            end
            default: begin
               first = rand64();
               last = rand64();
            end
         endcase
      end
      add_range(first, last);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents one queue entry at a time. A request is handed over
   // at an edge with start high and busy low; its results are predicted
   // there. start is computed once per edge so a back-to-back request
   // keeps it high without a dip.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         hold_cnt = 0;
      end else begin
         start_nxt = start;
         we_nxt = 1'b0;
         if (start && !busy) begin
            scan_divisors(req_data);
            start_nxt = 1'b0;
            hold_cnt = req_gap;
         end
         if (!start_nxt && work_q.size() != 0) begin
            if (hold_cnt != 0) begin
               hold_cnt--;
            end else if (work_q[0].kind == ENTRY_RANGE) begin
               req_data <= work_q[0].req;
               req_gap = work_q[0].gap;
               start_nxt = 1'b1;
               void'(work_q.pop_front());
            end else if (divisor_results_q.size() == 0 && !busy && !csr_we) begin
               // block idle: safe to change the target
               csr_wdata <= work_q[0].value;
               target_shadow = work_q[0].value;
               we_nxt = 1'b1;
               void'(work_q.pop_front());
            end
         end
         start <= start_nxt;
         csr_we <= we_nxt;
      end
   end

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: every strobed result is checked against the oldest one due.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      tds_pkg::rsp_type due;
      if (!reset && rsp_valid) begin
         if (divisor_results_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_data);
            mismatches++;
         end else begin
            due = divisor_results_q.pop_front();
            check_field("divisor", due.divisor, rsp_data.divisor);
            check_field("cofactor", due.cofactor, rsp_data.cofactor);
            check_field("pair_valid", 64'(due.pair_valid), 64'(rsp_data.pair_valid));
            check_field("span_error", 64'(due.span_error), 64'(rsp_data.span_error));
            check_field("last_of_run", 64'(due.last_of_run), 64'(rsp_data.last_of_run));
         end
      end
   end

   // Watchdog: fails the test when the idle count reaches IDLE_LIMIT with no request,
   // result or target write; a full 64-candidate range can hold back its first result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned ph;
      int unsigned n;
      logic [63:0] tv;

      // -- directed part --
      // target left at its reset value of zero: every nonzero candidate
      // divides, cofactor zero; candidate zero alone gives only an empty result
      add_range(64'd0, 64'd0);
      add_range(64'd0, 64'd5);
      // 2^4 * 3^2 * 5 * 7 * 11 * 13
      add_target(64'd720720);
      add_range(64'd1, 64'(SPAN_LIMIT));            // widest legal span
      add_range(64'd1, 64'(SPAN_LIMIT) + 64'd1);    // one too wide
      add_range(64'd10, 64'd9);                     // reversed by one
      add_range(TOP_VALUE, 64'd0);                  // reversed, extremes
      add_range(64'd0, TOP_VALUE);                  // far too wide
      add_range(64'd17, 64'd17);                    // no divisor
      add_range(64'd13, 64'd13);                    // one pair
      add_range(64'd720720 - 64'd5, 64'd720720);    // target itself
      add_range(TOP_VALUE - 64'd63, TOP_VALUE);     // ends at the top, none
      add_target(TOP_VALUE);
      add_range(TOP_VALUE - 64'd63, TOP_VALUE);     // top divides itself
      add_range(64'd0, 64'd63);
      add_range(64'd641, 64'd641);
      add_target(64'h8000_0000_0000_0000);
      add_range(64'd1, 64'd64);
      add_range(64'h7fff_ffff_ffff_ffe0, 64'h8000_0000_0000_001f);
      add_target(64'd1);
      add_range(64'd0, 64'd1);
      add_range(64'd2, 64'd2);

      // -- random part, one target per phase --
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0, 1: tv = smooth_number();
            2: tv = rand64();
            3: tv = 64'(1) << $urandom_range(0, 63);
            4: tv = smooth_number() * 64'($urandom_range(1, 3));
            default: tv = ($urandom_range(0, 1) == 0) ? 64'd0 : TOP_VALUE;
         endcase
         add_target(tv);
         for (n = 0; n < PHASE_RANGES; n++)
            add_random_range();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // everything handed over and every result back
      while (work_q.size() != 0 || start || divisor_results_q.size() != 0)
         @(posedge clock);
      // catch any stray result after the last one due
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- trial_division_divisor_scan_top.f -----
+incdir+design
design/tds_pkg.sv
design/tds_divider.sv
design/trial_division_divisor_scan_top.sv
test/trial_division_divisor_scan_top_tb.sv
